[rtl/fcb_pkg.sv]
`timescale 1ns / 1ps

package fcb_pkg;

    localparam logic [2:0] OP_MOVE_LEFT    = 3'd0;
    localparam logic [2:0] OP_MOVE_FRONT   = 3'd1;
    localparam logic [2:0] OP_TURN_HEADING = 3'd2;
    localparam logic [2:0] OP_TURN_PITCH   = 3'd3;
    localparam logic [2:0] OP_SNAP         = 3'd4;

    // Odd polynomial coefficients of the quarter-wave sine, Q30.
    localparam logic [31:0] SIN_K1  = 32'd1686629713;
    localparam logic [31:0] SIN_K3  = 32'd693598668;
    localparam logic [31:0] SIN_K5  = 32'd85569306;
    localparam logic [31:0] SIN_K7  = 32'd5026995;
    localparam logic [31:0] SIN_K9  = 32'd172272;
    localparam logic [31:0] SIN_K11 = 32'd3864;

    // A full turn is 23040 units of 1/64 degree, which is 512 * 45.
    localparam int          TURN_HALF_UNIT = 11520;
    localparam int          TURN_POW2_SHIFT = 9;
    localparam logic [32:0] TURN_OFFSET = 33'd1509949440;
    localparam logic [32:0] TURN_RECIP  = 33'd6108397933;
    localparam int          TURN_RECIP_SHIFT = 38;

    localparam int SNAP_HALF = 32768;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] move_distance;
        logic signed [15:0] turn_angle;
        logic signed [31:0] player_x;
        logic signed [31:0] player_y;
        logic signed [31:0] player_z;
    } fcb_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] left_x;
        logic signed [15:0] left_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } fcb_out_t;

    function automatic logic [31:0] horner_coef(input logic [2:0] idx);
        case (idx)
            3'd0:    horner_coef = SIN_K9;
            3'd1:    horner_coef = SIN_K7;
            3'd2:    horner_coef = SIN_K5;
            3'd3:    horner_coef = SIN_K3;
            default: horner_coef = SIN_K1;
        endcase
    endfunction

endpackage

[rtl/freefly_camera_basis_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  fcb_in_t: one camera command
// m_        out        m_valid / m_ready  fcb_out_t: position and basis
//
// One shared 34 x 34 multiplier does all multiplications, one product per cycle.
// A turn runs the angle step, four sine evaluations and the basis steps; a snap
// skips the angle step; a move steps through the three axes; others go to done.
// Reset is synchronous and restores the home position and the reset basis.
// A result waits in the output register while the next command is accepted;
// a command finishes only after the previous result has been taken.

module freefly_camera_basis_unit
    import fcb_pkg::*;
#(
    parameter int ANGLE_BITS      = 16,
    parameter int BASIS_FRAC_BITS = 14
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fcb_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fcb_out_t m_data
);

    localparam int AW = ANGLE_BITS;
    localparam int F  = BASIS_FRAC_BITS;
    localparam int BW = F + 2;
    localparam int NW = 16 + AW + 1;
    localparam logic signed [BW-1:0] ONE = BW'(1) <<< F;
    localparam logic [32:0]          ONE_U = 33'd1 << F;
    localparam logic signed [67:0]   ONE_W = 68'sd1 <<< F;
    localparam logic [AW-1:0]        QUARTER = AW'(1) << (AW - 2);

    typedef enum logic [3:0] {
        S_IDLE, S_MOVE, S_TURN, S_SIN_INIT, S_SIN_SQ, S_SIN_HORN, S_SIN_FIN,
        S_BAS0, S_BAS1, S_BAS2, S_BAS3, S_BAS4, S_BAS5, S_DONE
    } state_t;

    state_t state_reg;
    logic [2:0]         op_reg;
    logic signed [31:0] dist_reg;
    logic signed [15:0] ang_reg;
    logic signed [31:0] pos_reg [3];
    logic [AW-1:0]      heading_reg;
    logic [AW-1:0]      pitch_reg;
    logic signed [BW-1:0] trig_reg [4];
    logic signed [BW-1:0] front_x_reg, front_y_reg, front_z_reg;
    logic signed [BW-1:0] left_x_reg, left_z_reg;
    logic signed [BW-1:0] up_x_reg, up_y_reg, up_z_reg;
    logic [1:0]         idx_reg;
    logic [2:0]         horn_reg;
    logic [AW-2:0]      u_reg;
    logic               neg_reg;
    logic [29:0]        x2_reg;
    logic [31:0]        p_reg;
    logic signed [67:0] acc_reg;
    logic               m_valid_reg;
    fcb_out_t           m_data_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic signed [67:0] prod_rnd;
    logic [30:0]        sin_x;
    logic [AW-1:0]      sin_ph;
    logic [AW-2:0]      sin_u;
    logic [32:0]        sin_r;
    logic signed [BW-1:0] sin_mag;
    logic signed [NW-1:0] turn_n, turn_m;
    logic [32:0]        turn_mp;
    logic signed [BW-1:0] move_v;
    logic signed [67:0] move_sum;

    function automatic logic signed [67:0] round_q(input logic signed [67:0] v);
        round_q = (v + (68'sd1 <<< (F - 1))) >>> F;
    endfunction

    function automatic logic signed [BW-1:0] clamp_one(input logic signed [67:0] v);
        if (v > ONE_W) begin
            clamp_one = ONE;
        end else if (v < -ONE_W) begin
            clamp_one = -ONE;
        end else begin
            clamp_one = v[BW-1:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    always_comb begin
        case (idx_reg)
            2'd0:    sin_ph = heading_reg;
            2'd1:    sin_ph = heading_reg + QUARTER;
            2'd2:    sin_ph = pitch_reg;
            default: sin_ph = pitch_reg + QUARTER;
        endcase
        if (sin_ph[AW-2]) begin
            sin_u = QUARTER[AW-2:0] - {1'b0, sin_ph[AW-3:0]};
        end else begin
            sin_u = {1'b0, sin_ph[AW-3:0]};
        end
    end

    assign sin_x = 31'(u_reg) << (32 - AW);

    assign turn_n  = (NW'(ang_reg) <<< AW) + NW'(TURN_HALF_UNIT);
    assign turn_m  = turn_n >>> TURN_POW2_SHIFT;
    assign turn_mp = 33'(turn_m) + TURN_OFFSET;

    always_comb begin
        if (op_reg == OP_MOVE_LEFT) begin
            case (idx_reg)
                2'd0:    move_v = left_x_reg;
                2'd1:    move_v = '0;
                default: move_v = left_z_reg;
            endcase
        end else begin
            case (idx_reg)
                2'd0:    move_v = front_x_reg;
                2'd1:    move_v = front_y_reg;
                default: move_v = front_z_reg;
            endcase
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SIN_SQ: begin
                mul_a = 34'(sin_x);
                mul_b = 34'(sin_x);
            end
            S_SIN_HORN: begin
                mul_a = 34'(x2_reg);
                mul_b = 34'(p_reg);
            end
            S_SIN_FIN: begin
                mul_a = 34'(sin_x);
                mul_b = 34'(p_reg);
            end
            S_TURN: begin
                mul_a = 34'(turn_mp[31:0]);
                mul_b = 34'(TURN_RECIP);
            end
            S_BAS0: begin
                mul_a = 34'(trig_reg[3]);
                mul_b = 34'(trig_reg[0]);
            end
            S_BAS1: begin
                mul_a = 34'(trig_reg[3]);
                mul_b = 34'(trig_reg[1]);
            end
            S_BAS2: begin
                mul_a = 34'(front_y_reg);
                mul_b = 34'(left_z_reg);
            end
            S_BAS3: begin
                mul_a = 34'(front_z_reg);
                mul_b = 34'(left_x_reg);
            end
            S_BAS4: begin
                mul_a = 34'(front_x_reg);
                mul_b = 34'(left_z_reg);
            end
            S_BAS5: begin
                mul_a = 34'(front_y_reg);
                mul_b = 34'(left_x_reg);
            end
            S_MOVE: begin
                mul_a = 34'(dist_reg);
                mul_b = 34'(move_v);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_rnd = round_q(prod);
    assign move_sum = 68'(pos_reg[idx_reg]) + prod_rnd;

    always_comb begin
        sin_r = ({1'b0, prod[61:30]} + (33'd1 << (29 - F))) >> (30 - F);
        if (u_reg == '0) begin
            sin_mag = '0;
        end else if (u_reg[AW-2]) begin
            sin_mag = ONE;
        end else if (sin_r > ONE_U) begin
            sin_mag = ONE;
        end else begin
            sin_mag = sin_r[BW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pos_reg[0]  <= '0;
            pos_reg[1]  <= '0;
            pos_reg[2]  <= '0;
            heading_reg <= AW'(1) << (AW - 1);
            pitch_reg   <= '0;
            front_x_reg <= '0;
            front_y_reg <= '0;
            front_z_reg <= -ONE;
            left_x_reg  <= -ONE;
            left_z_reg  <= '0;
            up_x_reg    <= '0;
            up_y_reg    <= ONE;
            up_z_reg    <= '0;
            idx_reg     <= '0;
            horn_reg    <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg   <= s_data.operation;
                        dist_reg <= s_data.move_distance;
                        ang_reg  <= s_data.turn_angle;
                        idx_reg  <= '0;
                        case (s_data.operation)
                            OP_MOVE_LEFT, OP_MOVE_FRONT: state_reg <= S_MOVE;
                            OP_TURN_HEADING, OP_TURN_PITCH: state_reg <= S_TURN;
                            OP_SNAP: begin
                                pos_reg[0] <= s_data.player_x;
                                pos_reg[1] <= s_data.player_z;
                                pos_reg[2] <= sat32(68'(s_data.player_y) + 68'(SNAP_HALF));
                                state_reg  <= S_SIN_INIT;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_MOVE: begin
                    pos_reg[idx_reg] <= sat32(move_sum);
                    if (idx_reg == 2'd2) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                S_TURN: begin
                    if (op_reg == OP_TURN_HEADING) begin
                        heading_reg <= heading_reg + prod[TURN_RECIP_SHIFT +: AW];
                    end else begin
                        pitch_reg <= pitch_reg + prod[TURN_RECIP_SHIFT +: AW];
                    end
                    state_reg <= S_SIN_INIT;
                end
                S_SIN_INIT: begin
                    u_reg     <= sin_u;
                    neg_reg   <= sin_ph[AW-1];
                    state_reg <= S_SIN_SQ;
                end
                S_SIN_SQ: begin
                    x2_reg    <= prod[59:30];
                    p_reg     <= SIN_K11;
                    horn_reg  <= '0;
                    state_reg <= S_SIN_HORN;
                end
                S_SIN_HORN: begin
                    p_reg <= horner_coef(horn_reg) - prod[61:30];
                    if (horn_reg == 3'd4) begin
                        state_reg <= S_SIN_FIN;
                    end else begin
                        horn_reg <= horn_reg + 3'd1;
                    end
                end
                S_SIN_FIN: begin
                    trig_reg[idx_reg] <= neg_reg ? -sin_mag : sin_mag;
                    if (idx_reg == 2'd3) begin
                        state_reg <= S_BAS0;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_SIN_INIT;
                    end
                end
                S_BAS0: begin
                    front_x_reg <= prod_rnd[BW-1:0];
                    front_y_reg <= trig_reg[2];
                    left_x_reg  <= trig_reg[1];
                    left_z_reg  <= -trig_reg[0];
                    state_reg   <= S_BAS1;
                end
                S_BAS1: begin
                    front_z_reg <= prod_rnd[BW-1:0];
                    state_reg   <= S_BAS2;
                end
                S_BAS2: begin
                    up_x_reg  <= clamp_one(prod_rnd);
                    state_reg <= S_BAS3;
                end
                S_BAS3: begin
                    acc_reg   <= prod;
                    state_reg <= S_BAS4;
                end
                S_BAS4: begin
                    up_y_reg  <= clamp_one(round_q(acc_reg - prod));
                    state_reg <= S_BAS5;
                end
                S_BAS5: begin
                    up_z_reg  <= clamp_one(round_q(-prod));
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_data_reg.pos_x   <= pos_reg[0];
                        m_data_reg.pos_y   <= pos_reg[1];
                        m_data_reg.pos_z   <= pos_reg[2];
                        m_data_reg.front_x <= 16'(front_x_reg);
                        m_data_reg.front_y <= 16'(front_y_reg);
                        m_data_reg.front_z <= 16'(front_z_reg);
                        m_data_reg.left_x  <= 16'(left_x_reg);
                        m_data_reg.left_z  <= 16'(left_z_reg);
                        m_data_reg.up_x    <= 16'(up_x_reg);
                        m_data_reg.up_y    <= 16'(up_y_reg);
                        m_data_reg.up_z    <= 16'(up_z_reg);
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Command accepted while a command was in progress.");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("Result appeared outside the completion step.");

    a_horner_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SIN_HORN) |-> (horn_reg <= 3'd4))
        else $error("Polynomial step count overran.");

    a_up_limited: assert property (@(posedge aclk) disable iff (!aresetn)
        (up_y_reg <= ONE) && (up_y_reg >= -ONE) && (up_x_reg <= ONE) && (up_x_reg >= -ONE))
        else $error("Up vector component beyond unit range.");
`endif

endmodule

[dv/fcb_checker.sv]
`timescale 1ns / 1ps

module fcb_checker
    import fcb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  fcb_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  fcb_out_t m_data,
    output int       fail_count,
    output int       pending_words
);

    localparam int AB = 16;
    localparam int FB = 14;
    localparam longint UNIT = 64'sd1 << FB;
    localparam int QTR = 1 << (AB - 2);

    logic signed [31:0] cam_pos [3];
    logic [AB-1:0] heading_ph;
    logic [AB-1:0] pitch_ph;
    longint fwd_x, fwd_y, fwd_z, lft_x, lft_z, upv_x, upv_y, upv_z;
    fcb_out_t camera_words [$];

    function automatic longint rnd_shift(longint v, int s);
        longint t;
        t = v + (64'sd1 << (s - 1));
        return t >>> s;
    endfunction

    function automatic longint limit_unit(longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    function automatic logic signed [31:0] sat_q16(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint quarter_wave(int u);
        logic [63:0] x, x2, p, s, r;
        if (u == 0) return 0;
        if (u >= QTR) return UNIT;
        x = 64'(u) << (30 - (AB - 2));
        x2 = (x * x) >> 30;
        p = SIN_K11;
        p = SIN_K9 - ((x2 * p) >> 30);
        p = SIN_K7 - ((x2 * p) >> 30);
        p = SIN_K5 - ((x2 * p) >> 30);
        p = SIN_K3 - ((x2 * p) >> 30);
        p = SIN_K1 - ((x2 * p) >> 30);
        s = (x * p) >> 30;
        r = (s + (64'd1 << (29 - FB))) >> (30 - FB);
        if (r > 64'(UNIT)) r = 64'(UNIT);
        return longint'(r);
    endfunction

    function automatic longint sine_of(logic [AB-1:0] ph);
        int r;
        r = ph[AB-3:0];
        case (ph[AB-1:AB-2])
            2'd0: return quarter_wave(r);
            2'd1: return quarter_wave(QTR - r);
            2'd2: return -quarter_wave(r);
            default: return -quarter_wave(QTR - r);
        endcase
    endfunction

    function automatic logic [AB-1:0] turned(logic [AB-1:0] ph, logic signed [15:0] ang);
        longint v, stp;
        v = longint'(ang) * (64'sd1 << AB) + 11520;
        stp = (v >= 0) ? v / 23040 : -((-v + 23039) / 23040);
        return ph + stp[AB-1:0];
    endfunction

    task automatic rebuild_basis();
        longint sp, cp, st, ct;
        sp = sine_of(heading_ph);
        cp = sine_of(heading_ph + AB'(QTR));
        st = sine_of(pitch_ph);
        ct = sine_of(pitch_ph + AB'(QTR));
        fwd_x = rnd_shift(ct * sp, FB);
        fwd_y = st;
        fwd_z = rnd_shift(ct * cp, FB);
        lft_x = cp;
        lft_z = -sp;
        upv_x = limit_unit(rnd_shift(fwd_y * lft_z, FB));
        upv_y = limit_unit(rnd_shift(fwd_z * lft_x - fwd_x * lft_z, FB));
        upv_z = limit_unit(rnd_shift(-(fwd_y * lft_x), FB));
    endtask

    task automatic move_camera(longint d, longint vx, longint vy, longint vz);
        cam_pos[0] = sat_q16(longint'(cam_pos[0]) + rnd_shift(d * vx, FB));
        cam_pos[1] = sat_q16(longint'(cam_pos[1]) + rnd_shift(d * vy, FB));
        cam_pos[2] = sat_q16(longint'(cam_pos[2]) + rnd_shift(d * vz, FB));
    endtask

    task automatic apply_command(fcb_in_t c);
        fcb_out_t w;
        case (c.operation)
            OP_MOVE_LEFT: move_camera(c.move_distance, lft_x, 0, lft_z);
            OP_MOVE_FRONT: move_camera(c.move_distance, fwd_x, fwd_y, fwd_z);
            OP_TURN_HEADING: begin
                heading_ph = turned(heading_ph, c.turn_angle);
                rebuild_basis();
            end
            OP_TURN_PITCH: begin
                pitch_ph = turned(pitch_ph, c.turn_angle);
                rebuild_basis();
            end
            OP_SNAP: begin
                cam_pos[0] = c.player_x;
                cam_pos[1] = c.player_z;
                cam_pos[2] = sat_q16(longint'(c.player_y) + SNAP_HALF);
                rebuild_basis();
            end
            default: ;
        endcase
        w.pos_x = cam_pos[0];
        w.pos_y = cam_pos[1];
        w.pos_z = cam_pos[2];
        w.front_x = fwd_x[15:0];
        w.front_y = fwd_y[15:0];
        w.front_z = fwd_z[15:0];
        w.left_x = lft_x[15:0];
        w.left_z = lft_z[15:0];
        w.up_x = upv_x[15:0];
        w.up_y = upv_y[15:0];
        w.up_z = upv_z[15:0];
        camera_words.push_back(w);
    endtask

    task automatic report_word(fcb_out_t got, fcb_out_t want);
        fail_count++;
        if (fail_count <= 10)
            $display("Mismatch at %0t: expected %h, got %h", $time, want, got);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cam_pos[0] = '0;
            cam_pos[1] = '0;
            cam_pos[2] = '0;
            heading_ph = AB'(1) << (AB - 1);
            pitch_ph = '0;
            rebuild_basis();
            camera_words.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (camera_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected word at %0t: %h", $time, m_data);
                end else begin
                    if (m_data !== camera_words[0]) report_word(m_data, camera_words[0]);
                    void'(camera_words.pop_front());
                end
            end
            if (s_valid && s_ready) apply_command(s_data);
        end
        pending_words = camera_words.size();
    end

endmodule

[dv/tb_freefly_camera_basis_unit.sv]
`timescale 1ns / 1ps

module tb_freefly_camera_basis_unit;
    import fcb_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    fcb_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    fcb_out_t m_data;
    int       fail_count;
    int       pending_words;
    bit       calm = 1'b0;
    bit       hold_sink = 1'b0;
    int       sink_gap = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    freefly_camera_basis_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    fcb_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    function automatic logic signed [31:0] pick_q16();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
    endfunction

    function automatic fcb_in_t random_command();
        fcb_in_t c;
        c.operation = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
        c.move_distance = pick_q16();
        c.turn_angle = 16'($urandom);
        c.player_x = pick_q16();
        c.player_y = pick_q16();
        c.player_z = pick_q16();
        return c;
    endfunction

    task automatic send_command(fcb_in_t c);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_op(logic [2:0] op, logic signed [31:0] d, logic signed [15:0] a,
                           logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz);
        fcb_in_t c;
        c.operation = op;
        c.move_distance = d;
        c.turn_angle = a;
        c.player_x = px;
        c.player_y = py;
        c.player_z = pz;
        send_command(c);
    endtask

    always @(posedge aclk) begin
        if (!aresetn || hold_sink) begin
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (sink_gap > 0) begin
            m_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            sink_gap <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int guard;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_op(OP_MOVE_FRONT, 32'sh7fffffff, 0, 0, 0, 0);
        send_op(OP_MOVE_FRONT, 32'sh80000000, 0, 0, 0, 0);
        send_op(OP_MOVE_LEFT, 32'sh7fffffff, 0, 0, 0, 0);
        send_op(OP_MOVE_LEFT, 32'sh80000000, 0, 0, 0, 0);
        send_op(OP_TURN_HEADING, 0, 16'sh7fff, 0, 0, 0);
        send_op(OP_TURN_HEADING, 0, 16'sh8000, 0, 0, 0);
        send_op(OP_TURN_PITCH, 0, 5760, 0, 0, 0);
        send_op(OP_TURN_PITCH, 0, 5760, 0, 0, 0);
        send_op(OP_TURN_PITCH, 0, 16'sh7fff, 0, 0, 0);
        send_op(OP_TURN_PITCH, 0, -1, 0, 0, 0);
        send_op(OP_TURN_HEADING, 0, 1, 0, 0, 0);
        send_op(OP_SNAP, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_op(OP_MOVE_FRONT, 32'sh7fffffff, 0, 0, 0, 0);
        send_op(OP_SNAP, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_op(OP_MOVE_LEFT, 32'sh80000000, 0, 0, 0, 0);
        send_op(3'd5, 32'hffffffff, 16'hffff, -1, -1, -1);
        send_op(3'd6, 0, 0, 0, 0, 0);
        send_op(3'd7, 0, 0, 0, 0, 0);
        send_op(OP_SNAP, 0, 0, 0, 0, 0);

        hold_sink <= 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_sink <= 1'b0;
            end
            repeat (6) send_command(random_command());
        join

        for (int n = 0; n < 1830; n++) begin
            if (n == 900) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                guard = 0;
                while (pending_words != 0 && guard < 100000) begin
                    @(posedge aclk);
                    guard++;
                end
            end
            if (n == 1500) calm <= 1'b1;
            send_command(random_command());
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (pending_words != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
